// File: rtl/alclk_pkg.sv
// Package for the alarm clock controller: event codes, limits and widths.
// Has no dependencies; imported by alarm_clock_controller.
`timescale 1ns / 1ps
`default_nettype none
package alclk_pkg;

  localparam int TIME_W  = 18;
  localparam int FUNC_W  = 3;
  localparam int FLASH_W = 9;
  localparam int DISP_W  = 2;

  localparam int DAY_TICKS_DEF = 172800;

  localparam logic [FUNC_W-1:0] FUNC_HALFSEC = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_FLASH   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ARM     = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SNOOZE  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SET     = 3'd4;

  localparam logic [TIME_W-1:0]  ALARM_RESET  = 18'd57600;
  localparam logic [FLASH_W-1:0] PLAIN_END    = 9'd304;
  localparam logic [FLASH_W-1:0] SNOOZE_END   = 9'd404;
  localparam logic [FLASH_W-1:0] SNOOZE_PAUSE = 9'd99;

  localparam logic [DISP_W-1:0] DISP_ALARM = 2'd0;
  localparam logic [DISP_W-1:0] DISP_LAST  = 2'd2;

  // floor(v / 10) = (v * DIV10_MUL) >> DIV10_SHIFT for every 18-bit v
  localparam int DIV10_SHIFT = 22;
  localparam logic [18:0] DIV10_MUL = 19'd419431;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  function automatic int time_width(input int day_ticks);
    int w;
    w = $clog2(day_ticks + 1);
    return (w > TIME_W) ? w : TIME_W;
  endfunction

  function automatic logic [3:0] mod10(input logic [TIME_W-1:0] v);
    logic [DIV10_SHIFT+TIME_W-1:0] prod;
    logic [TIME_W-1:0]  q;
    logic [TIME_W-1:0]  r;
    prod = v * DIV10_MUL;
    q    = prod[DIV10_SHIFT +: TIME_W];
    r    = v - ((q << 3) + (q << 1));
    return r[3:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/alarm_clock_controller.sv
// Alarm clock controller: time of day, alarm ring/snooze, LED flash, display rotation.
// Depends on alclk_pkg.
// The result is registered and is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while m_axis_tready holds; state and result registers update together.
// s_axis_tready stays high while the result register is empty or being taken.
// Reset (rst, synchronous): time 0, all flags clear, display on alarm time,
// alarm_time back to 57600, no result pending.
`timescale 1ns / 1ps
`default_nettype none
module alarm_clock_controller
  import alclk_pkg::*;
#(
  parameter int DAY_TICKS = DAY_TICKS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  alarm_time_we,
  input  wire logic [TIME_W-1:0]     alarm_time_wdata,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // value[17:0], zero pad
  input  wire logic [FUNC_W-1:0]     s_axis_tuser,   // func[2:0]
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata    // time_now[17:0], alarm_led[18],
                                                     // armed_led[19], ringing[20],
                                                     // snoozed[21], display_select[23:22],
                                                     // set_rejected[24], zero pad
);

  localparam int TW = time_width(DAY_TICKS);
  localparam logic [TW:0] DAY_LIMIT = (TW + 1)'(DAY_TICKS);

  logic [TIME_W-1:0]  alarm_time;
  logic [TW-1:0]      elapsed;
  logic [3:0]         res10;
  logic [FLASH_W-1:0] flash_count;
  logic [1:0]         flash_m3;
  logic [2:0]         flash_m5;
  logic               armed;
  logic               ringing_flag;
  logic               snooze_flag;
  logic               led_lit;
  logic [DISP_W-1:0]  display_phase;
  logic               out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  logic [TW-1:0]      elapsed_next;
  logic [3:0]         res10_next;
  logic [FLASH_W-1:0] flash_count_next;
  logic [1:0]         flash_m3_next;
  logic [2:0]         flash_m5_next;
  logic               armed_next;
  logic               ringing_next;
  logic               snooze_next;
  logic               led_next;
  logic [DISP_W-1:0]  display_next;
  logic               rejected;
  logic               accept;
  logic [FUNC_W-1:0]  func;
  logic [TIME_W-1:0]  value;
  logic [TW:0]        elapsed_inc;
  logic               do_blink;
  logic               do_stop;

  assign func   = s_axis_tuser;
  assign value  = s_axis_tdata[TIME_W-1:0];
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign elapsed_inc = {1'b0, elapsed} + (TW + 1)'(1);

  always_comb begin
    elapsed_next     = elapsed;
    res10_next       = res10;
    flash_count_next = flash_count;
    flash_m3_next    = flash_m3;
    flash_m5_next    = flash_m5;
    armed_next       = armed;
    ringing_next     = ringing_flag;
    snooze_next      = snooze_flag;
    led_next         = led_lit;
    display_next     = display_phase;
    rejected         = 1'b0;
    do_blink         = 1'b0;
    do_stop          = 1'b0;

    unique case (func)
      FUNC_HALFSEC: begin
        if (elapsed_inc >= DAY_LIMIT) begin
          elapsed_next = '0;
          res10_next   = 4'd0;
        end else begin
          elapsed_next = elapsed_inc[TW-1:0];
          res10_next   = (res10 == 4'd9) ? 4'd0 : res10 + 4'd1;
        end
        if (res10_next == 4'd0) begin
          display_next = (display_phase < DISP_LAST) ? display_phase + 2'd1 : DISP_ALARM;
        end
      end
      FUNC_FLASH: begin
        if (ringing_flag) begin
          flash_count_next = flash_count + 9'd1;
          flash_m3_next    = (flash_m3 == 2'd2) ? 2'd0 : flash_m3 + 2'd1;
          flash_m5_next    = (flash_m5 == 3'd4) ? 3'd0 : flash_m5 + 3'd1;
          if (snooze_flag) begin
            if (flash_count_next > SNOOZE_END) begin
              do_stop = 1'b1;
            end else if (flash_count_next > SNOOZE_PAUSE) begin
              do_blink = 1'b1;
            end
          end else begin
            if (flash_count_next > PLAIN_END) begin
              do_stop = 1'b1;
            end else begin
              do_blink = 1'b1;
            end
          end
        end
      end
      FUNC_ARM: begin
        armed_next = !armed;
        do_stop    = armed;
      end
      FUNC_SNOOZE: begin
        if (ringing_flag) begin
          snooze_next      = 1'b1;
          led_next         = 1'b0;
          flash_count_next = '0;
          flash_m3_next    = 2'd0;
          flash_m5_next    = 3'd0;
        end
      end
      FUNC_SET: begin
        if ({{(TW + 1 - TIME_W){1'b0}}, value} <= DAY_LIMIT) begin
          elapsed_next = TW'(value);
          res10_next   = mod10(value);
        end else begin
          rejected = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (do_blink) begin
      if (flash_m3_next == 2'd0 && flash_m5_next == 3'd0) begin
        led_next = 1'b1;
      end else if (flash_m5_next == 3'd0) begin
        led_next = 1'b0;
      end
    end

    if (do_stop) begin
      flash_count_next = '0;
      flash_m3_next    = 2'd0;
      flash_m5_next    = 3'd0;
      ringing_next     = 1'b0;
      snooze_next      = 1'b0;
      led_next         = 1'b0;
    end

    if (armed_next && elapsed_next == TW'(alarm_time)) begin
      ringing_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_time    <= ALARM_RESET;
      elapsed       <= '0;
      res10         <= 4'd0;
      flash_count   <= '0;
      flash_m3      <= 2'd0;
      flash_m5      <= 3'd0;
      armed         <= 1'b0;
      ringing_flag  <= 1'b0;
      snooze_flag   <= 1'b0;
      led_lit       <= 1'b0;
      display_phase <= DISP_ALARM;
      out_valid     <= 1'b0;
    end else begin
      if (alarm_time_we) begin
        alarm_time <= alarm_time_wdata;
      end
      if (accept) begin
        elapsed       <= elapsed_next;
        res10         <= res10_next;
        flash_count   <= flash_count_next;
        flash_m3      <= flash_m3_next;
        flash_m5      <= flash_m5_next;
        armed         <= armed_next;
        ringing_flag  <= ringing_next;
        snooze_flag   <= snooze_next;
        led_lit       <= led_next;
        display_phase <= display_next;
        out_valid     <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= {7'd0, rejected, display_next, snooze_next, ringing_next,
                   armed_next, led_next, elapsed_next[TIME_W-1:0]};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  a_snooze_rings: assert property (@(posedge clk) disable iff (rst)
    snooze_flag |-> ringing_flag) else $error("snooze set without ringing");

  a_led_rings: assert property (@(posedge clk) disable iff (rst)
    led_lit |-> ringing_flag) else $error("alarm LED lit without ringing");

  a_flash_idle: assert property (@(posedge clk) disable iff (rst)
    !ringing_flag |-> (flash_count == '0 && flash_m3 == 2'd0 && flash_m5 == 3'd0))
    else $error("flash count running while silent");

  a_flash_bound: assert property (@(posedge clk) disable iff (rst)
    flash_count <= SNOOZE_END) else $error("flash count past end of ring");

  a_disp_range: assert property (@(posedge clk) disable iff (rst)
    display_phase <= DISP_LAST) else $error("display phase out of range");

endmodule
`default_nettype wire

// File: tb/alarm_clock_controller_tb.sv
// Self-checking bench for alarm_clock_controller: directed table, random ring episodes, noise.
// Predicts readouts from a clock model or the directed table; imports alclk_pkg.
`timescale 1ns / 1ps
module alarm_clock_controller_tb;
  import alclk_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE5 = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE7 = 3'd7;
  localparam int TIME_MAX    = (1 << TIME_W) - 1;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 25;

  typedef struct packed {
    logic              set_rej;
    logic [DISP_W-1:0] disp;
    logic              snoozed;
    logic              ringing;
    logic              armed_led;
    logic              alarm_led;
    logic [TIME_W-1:0] time_now;
  } readout_t;

  typedef struct {
    logic [FUNC_W-1:0] f;
    logic [TIME_W-1:0] v;
    bit                fixed;
    readout_t          res;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  alarm_time_we = 1'b0;
  logic [TIME_W-1:0]     alarm_time_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [FUNC_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // clock model state
  logic [TIME_W-1:0]  alarm_at = ALARM_RESET;
  logic [TIME_W-1:0]  tod = '0;
  logic [FLASH_W-1:0] flash_cnt = '0;
  logic               is_armed = 1'b0;
  logic               is_ringing = 1'b0;
  logic               is_snoozed = 1'b0;
  logic               led_on = 1'b0;
  logic [DISP_W-1:0]  disp_phase = DISP_ALARM;

  readout_t  readout_q[$];
  stim_row_t dir_rows[$];
  int        fails = 0;
  int        sent = 0;
  int        idle_cycles = 0;
  bit        no_idle = 1'b0;
  bit        rx_hold_req = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  alarm_clock_controller dut (
    .clk              (clk),
    .rst              (rst),
    .alarm_time_we    (alarm_time_we),
    .alarm_time_wdata (alarm_time_wdata),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata)
  );

  function automatic void ring_off();
    flash_cnt  = '0;
    is_ringing = 1'b0;
    is_snoozed = 1'b0;
    led_on     = 1'b0;
  endfunction

  function automatic void led_blink();
    if (flash_cnt % 15 == 0) begin
      led_on = 1'b1;
    end else if (flash_cnt % 5 == 0) begin
      led_on = 1'b0;
    end
  endfunction

  function automatic readout_t apply_event(input logic [FUNC_W-1:0] f,
                                           input logic [TIME_W-1:0] v);
    readout_t r;
    int       nt;
    logic     rej;
    rej = 1'b0;
    case (f)
      FUNC_HALFSEC: begin
        nt  = int'(tod) + 1;
        tod = (nt >= DAY_TICKS_DEF) ? '0 : nt[TIME_W-1:0];
        if (tod % 10 == 0) begin
          disp_phase = (disp_phase < DISP_LAST) ? disp_phase + 1'b1 : DISP_ALARM;
        end
      end
      FUNC_FLASH: begin
        if (is_ringing) begin
          flash_cnt = flash_cnt + 1'b1;
          if (is_snoozed) begin
            if (flash_cnt > SNOOZE_END) begin
              ring_off();
            end else if (flash_cnt > SNOOZE_PAUSE) begin
              led_blink();
            end
          end else if (flash_cnt > PLAIN_END) begin
            ring_off();
          end else begin
            led_blink();
          end
        end
      end
      FUNC_ARM: begin
        if (!is_armed) begin
          is_armed = 1'b1;
        end else begin
          is_armed = 1'b0;
          ring_off();
        end
      end
      FUNC_SNOOZE: begin
        if (is_ringing) begin
          is_snoozed = 1'b1;
          led_on     = 1'b0;
          flash_cnt  = '0;
        end
      end
      FUNC_SET: begin
        if (int'(v) <= DAY_TICKS_DEF) begin
          tod = v;
        end else begin
          rej = 1'b1;
        end
      end
      default: ;
    endcase
    if (is_armed && tod == alarm_at) begin
      is_ringing = 1'b1;
    end
    r.time_now  = tod;
    r.alarm_led = led_on;
    r.armed_led = is_armed;
    r.ringing   = is_ringing;
    r.snoozed   = is_snoozed;
    r.disp      = disp_phase;
    r.set_rej   = rej;
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] rand_time(input int hi);
    logic [31:0] w;
    w = $urandom_range(0, hi);
    return w[TIME_W-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic add_row(input logic [FUNC_W-1:0] f, input int v);
    stim_row_t row;
    row.f     = f;
    row.v     = v[TIME_W-1:0];
    row.fixed = 1'b0;
    row.res   = '0;
    dir_rows.push_back(row);
  endtask

  task automatic add_check(input logic [FUNC_W-1:0] f, input int v, input int t,
                           input bit led, input bit arm, input bit ring, input bit snz,
                           input int disp, input bit rej);
    stim_row_t row;
    row.f             = f;
    row.v             = v[TIME_W-1:0];
    row.fixed         = 1'b1;
    row.res.time_now  = t[TIME_W-1:0];
    row.res.alarm_led = led;
    row.res.armed_led = arm;
    row.res.ringing   = ring;
    row.res.snoozed   = snz;
    row.res.disp      = disp[DISP_W-1:0];
    row.res.set_rej   = rej;
    dir_rows.push_back(row);
  endtask

  task automatic offer(input logic [FUNC_W-1:0] f, input logic [TIME_W-1:0] v,
                       input bit fixed, input readout_t fixed_res);
    int       gap;
    readout_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {{(IN_DATA_W-TIME_W){1'b0}}, v};
    do @(posedge clk); while (!s_axis_tready);
    pred = apply_event(f, v);
    readout_q.push_back(fixed ? fixed_res : pred);
    sent++;
  endtask

  task automatic send(input logic [FUNC_W-1:0] f, input logic [TIME_W-1:0] v);
    offer(f, v, 1'b0, '0);
  endtask

  task automatic send_noise();
    logic [31:0] w;
    w = $urandom_range(0, 7);
    send(w[FUNC_W-1:0], ($urandom_range(0, 1) == 0) ? rand_time(TIME_MAX)
                                                     : rand_time(DAY_TICKS_DEF));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (readout_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_alarm(input logic [TIME_W-1:0] a);
    wait_idle();
    alarm_time_we    <= 1'b1;
    alarm_time_wdata <= a;
    @(posedge clk);
    alarm_time_we <= 1'b0;
    alarm_at = a;
  endtask

  // approach the alarm moment, arm if needed, then ring with optional snooze, noise, disarm
  task automatic ring_episode();
    int                k;
    int                n;
    int                snooze_at;
    logic [TIME_W-1:0] start;
    k = $urandom_range(0, 12);
    if (int'(alarm_at) > DAY_TICKS_DEF) begin
      start = rand_time(DAY_TICKS_DEF);
    end else if (int'(alarm_at) >= k) begin
      start = alarm_at - k[TIME_W-1:0];
    end else begin
      start = alarm_at;
      k     = 0;
    end
    send(FUNC_SET, start);
    if (!is_armed) begin
      send(FUNC_ARM, rand_time(TIME_MAX));
    end
    repeat (k) send(FUNC_HALFSEC, rand_time(TIME_MAX));
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(400, 480) : $urandom_range(5, 60);
    snooze_at = ($urandom_range(0, 1) == 0) ? $urandom_range(0, n / 8) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == snooze_at) begin
        send(FUNC_SNOOZE, rand_time(TIME_MAX));
      end
      if ($urandom_range(0, 39) == 0) begin
        send_noise();
      end
      send(FUNC_FLASH, rand_time(TIME_MAX));
    end
    if ($urandom_range(0, 2) == 0) begin
      send(FUNC_ARM, rand_time(TIME_MAX));
    end
  endtask

  // receiver: random stalls, or one long hold-off on request
  initial begin
    int len;
    forever begin
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        len = pick_gap();
        if (len == 0) begin
          m_axis_tready <= 1'b1;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else begin
          m_axis_tready <= 1'b0;
          repeat (len) @(posedge clk);
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : readout_mon
    readout_t got;
    readout_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(readout_t)-1:0];
      if (readout_q.size() == 0) begin
        $error("readout with no request pending: %h", m_axis_tdata);
        fails++;
      end else begin
        want = readout_q.pop_front();
        check_field("time_now", want.time_now, got.time_now);
        check_field("alarm_led", want.alarm_led, got.alarm_led);
        check_field("armed_led", want.armed_led, got.armed_led);
        check_field("ringing", want.ringing, got.ringing);
        check_field("snoozed", want.snoozed, got.snoozed);
        check_field("display_select", want.disp, got.disp);
        check_field("set_rejected", want.set_rej, got.set_rej);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [TIME_W-1:0] a;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    add_check(FUNC_HALFSEC, 0, 1, 0, 0, 0, 0, 0, 0);
    add_check(FUNC_SET, DAY_TICKS_DEF, DAY_TICKS_DEF, 0, 0, 0, 0, 0, 0);
    add_check(FUNC_SET, DAY_TICKS_DEF + 1, DAY_TICKS_DEF, 0, 0, 0, 0, 0, 1);
    add_check(FUNC_SET, TIME_MAX, DAY_TICKS_DEF, 0, 0, 0, 0, 0, 1);
    add_check(FUNC_HALFSEC, 0, 0, 0, 0, 0, 0, 1, 0);
    add_row(FUNC_SET, DAY_TICKS_DEF - 1);
    add_check(FUNC_HALFSEC, 0, 0, 0, 0, 0, 0, 2, 0);
    add_row(FUNC_SET, 9);
    add_check(FUNC_HALFSEC, 0, 10, 0, 0, 0, 0, 0, 0);
    add_check(FUNC_FLASH, TIME_MAX, 10, 0, 0, 0, 0, 0, 0);
    add_check(FUNC_SNOOZE, TIME_MAX, 10, 0, 0, 0, 0, 0, 0);
    add_check(FUNC_SPARE5, TIME_MAX, 10, 0, 0, 0, 0, 0, 0);
    add_check(FUNC_SPARE6, 18'h15555, 10, 0, 0, 0, 0, 0, 0);
    add_check(FUNC_SPARE7, 0, 10, 0, 0, 0, 0, 0, 0);
    add_row(FUNC_SET, ALARM_RESET - 1);
    add_check(FUNC_ARM, 0, ALARM_RESET - 1, 0, 1, 0, 0, 0, 0);
    add_check(FUNC_HALFSEC, 0, ALARM_RESET, 0, 1, 1, 0, 1, 0);
    add_row(FUNC_FLASH, 0);
    add_check(FUNC_SNOOZE, 0, ALARM_RESET, 0, 1, 1, 1, 1, 0);
    add_check(FUNC_ARM, 0, ALARM_RESET, 0, 0, 0, 0, 1, 0);
    add_check(FUNC_ARM, 0, ALARM_RESET, 0, 1, 1, 0, 1, 0);
    add_check(FUNC_SET, 0, 0, 0, 1, 1, 0, 1, 0);
    add_check(FUNC_ARM, 0, 0, 0, 0, 0, 0, 1, 0);
    foreach (dir_rows[i]) begin
      offer(dir_rows[i].f, dir_rows[i].v, dir_rows[i].fixed, dir_rows[i].res);
    end

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: a = '0;
        1: a = DAY_TICKS_DEF;
        2: a = TIME_MAX;
        3: a = rand_time(DAY_TICKS_DEF);
        default: a = DAY_TICKS_DEF - 1;
      endcase
      set_alarm(a);
      no_idle = (p == 2);
      if (p == 1) begin
        rx_hold_req = 1'b1;
      end
      a = sent[TIME_W-1:0];
      while (sent - int'(a) < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 8)) send_noise();
        end else begin
          ring_episode();
        end
      end
    end
    no_idle = 1'b0;

    wait_idle();
    repeat (4) @(posedge clk);
    if (readout_q.size() != 0) begin
      $error("%0d readouts never arrived", readout_q.size());
      fails++;
    end
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/alclk_pkg.sv
rtl/alarm_clock_controller.sv
tb/alarm_clock_controller_tb.sv
